FILE: src/u16u8_pkg.sv
`default_nettype none

package u16u8_pkg;

    localparam int MAX_BYTES = 6;

    localparam logic [15:0] ASCII_MASK = 16'hFF80;
    localparam logic [15:0] TWO_MASK   = 16'hF800;
    localparam logic [15:0] SURR_MASK  = 16'hFC00;
    localparam logic [15:0] HIGH_SURR  = 16'hD800;
    localparam logic [15:0] LOW_SURR   = 16'hDC00;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    typedef logic [2:0] cnt_t;

    // One item's worth of output bytes; bytes[0] goes out first.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        cnt_t                      cnt;
    } run_t;

    // Three-byte form of a 16-bit value, first byte at index 0.
    function automatic logic [2:0][7:0] enc3(input logic [15:0] u);
        logic [2:0][7:0] r;
        r[0] = LEAD3 | {4'b0, u[15:12]};
        r[1] = CONT  | {2'b0, u[11:6]};
        r[2] = CONT  | {2'b0, u[5:0]};
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/u16u8_front.sv
`default_nettype none

module u16u8_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [15:0]     s_code_unit,
    input  wire logic            q_full,
    output logic                 push_valid,
    output u16u8_pkg::run_t      push_run
);
    import u16u8_pkg::*;

    logic        held_valid_reg, held_valid_next;
    logic [15:0] held_high_reg, held_high_next;
    logic        accept;
    logic        is_low, is_high, hold_new;
    logic [2:0][7:0] nb;
    logic [2:0][7:0] held3;
    cnt_t        nn;
    logic [20:0] cp;

    always_comb begin
        s_ready = !q_full;
        accept  = s_valid && !q_full;
        is_low  = (s_code_unit & SURR_MASK) == LOW_SURR;
        is_high = (s_code_unit & SURR_MASK) == HIGH_SURR;
        held3   = enc3(held_high_reg);
        cp      = 21'h01_0000 + {1'b0, held_high_reg[9:0], s_code_unit[9:0]};

        // bytes for the new unit alone
        nb       = '0;
        nn       = '0;
        hold_new = 1'b0;
        if (s_code_unit == 16'h0000) begin
            nb[0] = 8'h00;
            nn    = cnt_t'(1);
        end else if ((s_code_unit & ASCII_MASK) == 16'h0000) begin
            nb[0] = s_code_unit[7:0];
            nn    = cnt_t'(1);
        end else if ((s_code_unit & TWO_MASK) == 16'h0000) begin
            nb[0] = LEAD2 | {3'b0, s_code_unit[10:6]};
            nb[1] = CONT  | {2'b0, s_code_unit[5:0]};
            nn    = cnt_t'(2);
        end else if (is_high) begin
            hold_new = 1'b1;
        end else begin
            nb = enc3(s_code_unit);
            nn = cnt_t'(3);
        end

        push_run = '0;
        if (held_valid_reg && is_low) begin
            push_run.bytes[0] = LEAD4 | {5'b0, cp[20:18]};
            push_run.bytes[1] = CONT  | {2'b0, cp[17:12]};
            push_run.bytes[2] = CONT  | {2'b0, cp[11:6]};
            push_run.bytes[3] = CONT  | {2'b0, cp[5:0]};
            push_run.cnt      = cnt_t'(4);
            held_valid_next   = 1'b0;
            held_high_next    = '0;
        end else if (held_valid_reg) begin
            push_run.bytes[2:0] = held3;
            push_run.bytes[5:3] = nb;
            push_run.cnt        = cnt_t'(3) + nn;
            held_valid_next     = hold_new;
            held_high_next      = hold_new ? s_code_unit : 16'h0000;
        end else begin
            push_run.bytes[2:0] = nb;
            push_run.cnt        = nn;
            held_valid_next     = hold_new;
            held_high_next      = hold_new ? s_code_unit : 16'h0000;
        end

        push_valid = accept && (push_run.cnt != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_high_reg  <= '0;
        end else if (accept) begin
            held_valid_reg <= held_valid_next;
            held_high_reg  <= held_high_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/u16u8_fifo.sv
`default_nettype none

module u16u8_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push_valid,
    input  wire u16u8_pkg::run_t push_run,
    output logic                 q_full,
    input  wire logic            q_pop,
    output logic                 q_valid,
    output u16u8_pkg::run_t      q_run
);
    import u16u8_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    run_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        q_full  = count_reg == CNT_W'(DEPTH);
        q_valid = count_reg != '0;
        q_run   = slot_reg[rd_ptr_reg];
        count_next = count_reg;
        if (push_valid && !(q_pop && q_valid)) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!push_valid && q_pop && q_valid) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            slot_reg[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push_valid) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (q_pop && q_valid) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/u16u8_back.sv
`default_nettype none

module u16u8_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    input  wire u16u8_pkg::run_t q_run,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [7:0]           m_out_byte,
    output logic                 m_run_end
);
    import u16u8_pkg::*;

    run_t       cur_reg;
    cnt_t       idx_reg;
    logic       busy_reg;
    logic       m_valid_reg;
    logic [7:0] byte_reg;
    logic       end_reg;
    logic       out_free, emit, last;

    always_comb begin
        out_free   = !m_valid_reg || m_ready;
        emit       = busy_reg && out_free;
        last       = idx_reg == (cur_reg.cnt - cnt_t'(1));
        // take the next run on the cycle the current one sends its last byte
        q_pop      = q_valid && (!busy_reg || (emit && last));
        m_valid    = m_valid_reg;
        m_out_byte = byte_reg;
        m_run_end  = end_reg;
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            byte_reg <= cur_reg.bytes[idx_reg];
            end_reg  <= last;
        end
        if (q_pop) begin
            cur_reg <= q_run;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (emit && last) begin
                busy_reg <= 1'b0;
            end else if (emit) begin
                idx_reg <= idx_reg + cnt_t'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/utf16_to_utf8_encoder_unit.sv
// channel   direction  ports                              word
// s_        in         s_valid s_ready s_code_unit[15:0]  one UTF-16 code unit
// m_        out        m_valid m_ready m_out_byte[7:0]    one UTF-8 byte, with
//                      m_run_end                          last-of-item flag
//
// The output delivers one byte per cycle while m_ready is high and runs are
// waiting; an item yields 1 to 6 bytes, and a high surrogate with nothing
// held yields none. Sustained rate is set by the byte-serial back stage.
// With the queue and back stage idle, m_valid rises once the word has passed
// the run queue, the back stage's current run register and the output register.
// s_ready drops only when the run queue (QUEUE_DEPTH entries) is full.
// aresetn is synchronous, active low; it drops any held surrogate and queue.
`default_nettype none

module utf16_to_utf8_encoder_unit #(
    parameter int QUEUE_DEPTH = 2   // run queue entries, 2 or more
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_code_unit,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_run_end
);
    import u16u8_pkg::*;

    // front: classify the unit, pair surrogates, build the byte run
    logic push_valid;
    run_t push_run;
    logic q_full;
    // queue to the back stage
    logic q_pop;
    logic q_valid;
    run_t q_run;

    u16u8_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_unit (s_code_unit),
        .q_full      (q_full),
        .push_valid  (push_valid),
        .push_run    (push_run)
    );

    // decouple classification from byte serialization
    u16u8_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_run   (push_run),
        .q_full     (q_full),
        .q_pop      (q_pop),
        .q_valid    (q_valid),
        .q_run      (q_run)
    );

    // back: drain each run a byte per cycle, while the output is free, into the output register
    u16u8_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_run      (q_run),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_end  (m_run_end)
    );

`ifndef SYNTHESIS
    // a queued run always carries between one and six bytes
    a_run_len: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (push_run.cnt != '0 && push_run.cnt <= cnt_t'(MAX_BYTES)))
        else $error("queued run has bad length");

    // a terminator word always queues a run ending in a zero byte
    a_term: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_code_unit == 16'h0000) |->
            (push_valid && push_run.bytes[push_run.cnt - cnt_t'(1)] == 8'h00))
        else $error("terminator not queued");

    // the back stage only pops a non-empty queue
    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

FILE: bench/utf8_byte_checker.sv
`timescale 1ns / 1ps

module utf8_byte_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [15:0] s_code_unit,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [7:0]  m_out_byte,
    input  wire logic        m_run_end,
    output int               errors,
    output int               pending
);
    import u16u8_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } utf8_byte_t;

    localparam int REPORT_LIMIT = 10;

    utf8_byte_t  due_bytes[$];
    logic [15:0] held_unit   = '0;
    logic        holding     = 1'b0;
    int          mismatches  = 0;
    int          bytes_seen  = 0;

    function automatic logic [23:0] three_byte_form(input logic [15:0] u);
        return {LEAD3 | {4'b0, u[15:12]}, CONT | {2'b0, u[11:6]}, CONT | {2'b0, u[5:0]}};
    endfunction

    // Encode one accepted word and queue the bytes it must produce.
    function automatic void encode_unit(input logic [15:0] u);
        logic [7:0]  run [MAX_BYTES];
        logic [23:0] tri3;
        logic [20:0] cp;
        int          n;
        logic        joined;
        n      = 0;
        joined = 1'b0;
        if (holding) begin
            if ((u & SURR_MASK) == LOW_SURR) begin
                cp     = 21'h10000 + {1'b0, held_unit[9:0], u[9:0]};
                run[0] = LEAD4 | {5'b0, cp[20:18]};
                run[1] = CONT | {2'b0, cp[17:12]};
                run[2] = CONT | {2'b0, cp[11:6]};
                run[3] = CONT | {2'b0, cp[5:0]};
                n      = 4;
                joined = 1'b1;
            end else begin
                tri3   = three_byte_form(held_unit);
                run[0] = tri3[23:16];
                run[1] = tri3[15:8];
                run[2] = tri3[7:0];
                n      = 3;
            end
            holding   = 1'b0;
            held_unit = '0;
        end
        if (!joined) begin
            if (u == 16'h0000) begin
                run[n] = 8'h00;
                n      = n + 1;
            end else if ((u & ASCII_MASK) == 16'h0000) begin
                run[n] = u[7:0];
                n      = n + 1;
            end else if ((u & TWO_MASK) == 16'h0000) begin
                run[n]     = LEAD2 | {3'b0, u[10:6]};
                run[n + 1] = CONT | {2'b0, u[5:0]};
                n          = n + 2;
            end else if ((u & SURR_MASK) == HIGH_SURR) begin
                held_unit = u;
                holding   = 1'b1;
            end else begin
                tri3       = three_byte_form(u);
                run[n]     = tri3[23:16];
                run[n + 1] = tri3[15:8];
                run[n + 2] = tri3[7:0];
                n          = n + 3;
            end
        end
        for (int i = 0; i < n; i++)
            due_bytes.push_back('{value: run[i], last: (i == n - 1)});
    endfunction

    task automatic note_mismatch(input string what, input utf8_byte_t want, input logic has_want);
        mismatches = mismatches + 1;
        if (mismatches <= REPORT_LIMIT) begin
            if (has_want)
                $display("%0t %s byte %0d: expected %02h last %0b, got %02h last %0b",
                         $time, what, bytes_seen, want.value, want.last,
                         m_out_byte, m_run_end);
            else
                $display("%0t %s byte %0d: got %02h last %0b",
                         $time, what, bytes_seen, m_out_byte, m_run_end);
        end
    endtask

    always @(posedge aclk) begin
        utf8_byte_t want;
        if (!aresetn) begin
            due_bytes.delete();
            holding   = 1'b0;
            held_unit = '0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_bytes.size() == 0) begin
                    want = '0;
                    note_mismatch("unexpected", want, 1'b0);
                end else begin
                    want = due_bytes.pop_front();
                    if (want.value !== m_out_byte || want.last !== m_run_end)
                        note_mismatch("mismatch", want, 1'b1);
                end
                bytes_seen = bytes_seen + 1;
            end
            if (s_valid && s_ready)
                encode_unit(s_code_unit);
        end
        pending <= due_bytes.size();
        errors  <= mismatches;
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // Longest run of cycles with no word moving on either channel.
    localparam int QUIET_LIMIT     = 2000;
    localparam int WORDS_PER_PHASE = 39;
    localparam int DRAIN_CYCLES    = 8;

    // Boundaries of every encoding length, surrogate pairs at both ends of
    // their range, lone low surrogates, and a held high surrogate broken by
    // ASCII, by another high surrogate, by a terminator, by a two-byte and
    // by a three-byte unit (the last gives the full six bytes).
    localparam logic [15:0] DIRECTED [25] = '{
        16'h0000, 16'h0001, 16'h007F, 16'h0080, 16'h07FF,
        16'h0800, 16'h8000, 16'hD7FF, 16'hE000, 16'hFFFF,
        16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF, 16'hDC00,
        16'hDFFF, 16'hD800, 16'h0041, 16'hDBFF, 16'hD800,
        16'h0000, 16'hD912, 16'h00E9, 16'hDABC, 16'hFFFE
    };

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [15:0] s_code_unit = 16'h0000;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_run_end;

    int errors;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    utf16_to_utf8_encoder_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_unit (s_code_unit),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_run_end   (m_run_end)
    );

    utf8_byte_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_unit (s_code_unit),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_run_end   (m_run_end),
        .errors      (errors),
        .pending     (pending)
    );

    // Stall the byte side at random; a zero percentage keeps ready high.
    always @(posedge aclk) begin
        m_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // Abort when nothing has moved for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[utf16_to_utf8_encoder_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one word and return at the edge that takes it. Valid is lowered
    // only for an idle gap, so back-to-back words keep it high throughout.
    task automatic send_word(input logic [15:0] u);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_code_unit <= u;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    function automatic logic [15:0] random_bmp_unit();
        logic [15:0] u;
        do
            u = 16'($urandom_range(16'hFFFF, 16'h0800));
        while ((u & 16'hF000) == 16'hD000 && ((u & 16'hFC00) == 16'hD800 ||
                                               (u & 16'hFC00) == 16'hDC00));
        return u;
    endfunction

    // Send one group of words: mostly well-formed text with random content,
    // the rest broken pairs, lone surrogates and raw noise.
    task automatic send_random_group(inout int sent);
        int          pick;
        logic [15:0] low10;
        pick  = $urandom_range(99);
        low10 = 16'($urandom_range(16'h03FF));
        if (pick < 20) begin
            send_word(16'($urandom_range(16'h007F, 16'h0001)));
            sent = sent + 1;
        end else if (pick < 35) begin
            send_word(16'($urandom_range(16'h07FF, 16'h0080)));
            sent = sent + 1;
        end else if (pick < 50) begin
            send_word(random_bmp_unit());
            sent = sent + 1;
        end else if (pick < 70) begin
            // well-formed pair: high then low, both payloads random
            send_word(16'hD800 | low10);
            send_word(16'hDC00 | 16'($urandom_range(16'h03FF)));
            sent = sent + 2;
        end else if (pick < 75) begin
            send_word(16'h0000);
            sent = sent + 1;
        end else if (pick < 80) begin
            send_word(16'hDC00 | low10);
            sent = sent + 1;
        end else if (pick < 88) begin
            // follow a high surrogate with any random word, which may break the pair or complete it
            send_word(16'hD800 | low10);
            send_word(16'($urandom_range(16'hFFFF)));
            sent = sent + 2;
        end else begin
            send_word(16'($urandom_range(16'hFFFF)));
            sent = sent + 1;
        end
    endtask

    initial begin
        int sent;
        // Hold reset, then release it.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words with both sides running at full rate.
        foreach (DIRECTED[i])
            send_word(DIRECTED[i]);

        // Random words across the idling phases: none, sender idle,
        // receiver stalling, both lightly.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            sent = 0;
            while (sent < WORDS_PER_PHASE)
                send_random_group(sent);
        end

        // Flush any surrogate still held, then drop valid.
        send_word(16'h0000);
        s_valid <= 1'b0;
        @(posedge aclk);

        // Drain every expected byte, then keep watching for strays.
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0 && pending == 0)
            $display("[utf16_to_utf8_encoder_unit] OK");
        else
            $display("[utf16_to_utf8_encoder_unit] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
src/u16u8_pkg.sv
src/u16u8_front.sv
src/u16u8_fifo.sv
src/u16u8_back.sv
src/utf16_to_utf8_encoder_unit.sv
bench/utf8_byte_checker.sv
bench/tb_top.sv
